// ----- hdl/trwst_pkg.sv -----
// Package for the transaction read/write set tracker.
// Holds the access, mark and status codes and the decision struct.
// No dependencies.
`default_nettype none

package trwst_pkg;

  // Default number of set entries
  localparam int SET_ENTRIES_DEF = 64;

  localparam int KEY_W  = 64;
  localparam int MARK_W = 3;
  localparam int CNT_W  = 7;
  localparam int RAM_W  = KEY_W + MARK_W;

  localparam logic [CNT_W-1:0] INSERT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_DELETE = 2'd3
  } mode_t;

  typedef enum logic [MARK_W-1:0] {
    MK_NONE   = 3'd0,
    MK_READ   = 3'd1,
    MK_UPDATE = 3'd2,
    MK_INSERT = 3'd3,
    MK_DELETE = 3'd4,
    MK_INSDEL = 3'd5
  } mark_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DELETED  = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_BADDEL   = 3'd3,
    ST_READONLY = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  // Outcome of one access, from the rule logic to the sequencer
  typedef struct packed {
    status_t          status;
    logic             cancelled;
    logic             mem_we;
    logic             alloc;
    mark_t            new_mark;
    logic             written;
    logic [CNT_W-1:0] inserts;
    mark_t            entry_kind;
  } rules_t;

endpackage

`default_nettype wire

// ----- hdl/trwst_ram.sv -----
// Generic simple dual-port RAM with registered read data.
// One write port and one read port; no dependencies.
`default_nettype none

module trwst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/trwst_rules.sv -----
// Transition rules of the read/write set: given the lookup result, decide
// status, new mark, insert count and written flag. Depends on trwst_pkg.
`default_nettype none

module trwst_rules
  import trwst_pkg::*;
(
  input  wire mode_t            mode,
  input  wire logic             read_only,
  input  wire logic             found,
  input  wire mark_t            mark,
  input  wire logic             full,
  input  wire logic [CNT_W-1:0] inserts,
  input  wire logic             written,
  output      rules_t           res
);

  always_comb begin
    res            = '0;
    res.status     = ST_OK;
    res.new_mark   = mark;
    res.written    = written;
    res.inserts    = inserts;
    res.entry_kind = found ? mark : MK_NONE;

    if (mode != MODE_READ && read_only) begin
      // Reject writes, report the current mark
      res.status = ST_READONLY;
    end else if (found) begin
      unique case (mode)
        MODE_READ: begin
          if (mark == MK_DELETE || mark == MK_INSDEL) begin
            res.status = ST_DELETED;
          end
        end
        MODE_UPDATE: begin
          if (mark == MK_DELETE) begin
            res.status = ST_DELETED;
          end else if (mark != MK_UPDATE && mark != MK_INSERT) begin
            res.mem_we     = 1'b1;
            res.new_mark   = MK_UPDATE;
            res.entry_kind = MK_UPDATE;
            res.written    = 1'b1;
          end
        end
        MODE_INSERT: begin
          res.status = ST_EXISTS;
        end
        MODE_DELETE: begin
          case (mark)
            MK_READ: begin
              res.mem_we     = 1'b1;
              res.new_mark   = MK_DELETE;
              res.entry_kind = MK_DELETE;
              res.written    = 1'b1;
            end
            MK_UPDATE: begin
              res.mem_we     = 1'b1;
              res.new_mark   = MK_DELETE;
              res.entry_kind = MK_DELETE;
            end
            MK_INSERT: begin
              res.mem_we     = 1'b1;
              res.new_mark   = MK_INSDEL;
              res.entry_kind = MK_INSDEL;
              res.cancelled  = 1'b1;
              if (inserts != '0) begin
                res.inserts = inserts - CNT_W'(1);
              end
            end
            default: begin
              res.status = ST_BADDEL;
            end
          endcase
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end else if (mode == MODE_DELETE) begin
      res.status = ST_BADDEL;
    end else begin
      // New key: allocate the next free entry, or report a full table
      if (full) begin
        res.status     = ST_FULL;
        res.entry_kind = MK_NONE;
      end else begin
        res.mem_we = 1'b1;
        res.alloc  = 1'b1;
        case (mode)
          MODE_READ:   res.new_mark = MK_READ;
          MODE_UPDATE: res.new_mark = MK_UPDATE;
          default:     res.new_mark = MK_INSERT;
        endcase
        res.entry_kind = res.new_mark;
        if (mode == MODE_UPDATE) begin
          res.written = 1'b1;
        end
        if (mode == MODE_INSERT && inserts != INSERT_MAX) begin
          res.inserts = inserts + CNT_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/transaction_rw_set_tracker_core.sv -----
// Top level of the transaction read/write set tracker: sequencer, set
// memory and rule logic. Depends on trwst_pkg, trwst_ram, trwst_rules.
`default_nettype none

// Each access word is looked up by scanning the set memory one entry per
// cycle through its single read port, starting at entry 0, and the scan
// stops early on a hit. Entries are filled in order and never freed, so a
// fill count marks which entries are live and no clearing pass is needed
// after reset. An access scans at most the live entries and may then wait
// for the result register to drain. The block takes one access at a time;
// in_tready is high only while it is idle. The read-only register may be
// written at any time the block is idle.

module transaction_rw_set_tracker_core
  import trwst_pkg::*;
#(
  parameter int SET_ENTRIES = SET_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // read_only_txn
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [71:0] in_tdata,      // mode[1:0], block_id[33:2],
                                          // tuple_offset[65:34], zero pad
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata      // status[2:0], insert_cancelled[3],
                                          // written[4], inserts_now[11:5],
                                          // entry_kind[14:12], zero pad
);

  localparam int AW = $clog2(SET_ENTRIES);
  localparam int CW = $clog2(SET_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic             ro_r;
  logic [KEY_W-1:0] key_r, key_nxt;
  mode_t            mode_r, mode_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             found_r, found_nxt;
  logic [AW-1:0]    hit_idx_r, hit_idx_nxt;
  mark_t            hit_mark_r, hit_mark_nxt;
  logic [CNT_W-1:0] inserts_r, inserts_nxt;
  logic             written_r, written_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [14:0]      out_data_r, out_data_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [RAM_W-1:0] ram_rdata;
  logic             hit_now;
  logic             out_free;
  rules_t           rules;

  // Set memory: key in the high bits, mark in the low bits
  trwst_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SET_ENTRIES)
  ) u_set_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  trwst_rules u_rules (
    .mode      (mode_r),
    .read_only (ro_r),
    .found     (found_r),
    .mark      (hit_mark_r),
    .full      (count_r == CW'(SET_ENTRIES)),
    .inserts   (inserts_r),
    .written   (written_r),
    .res       (rules)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign out_free   = !out_valid_r || out_tready;
  assign hit_now    = rd_pend_r && (ram_rdata[RAM_W-1:MARK_W] == key_r);

  // Sequencer: accept, scan, write back and load the result
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    mode_nxt      = mode_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    rd_pend_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    hit_mark_nxt  = hit_mark_r;
    inserts_nxt   = inserts_r;
    written_nxt   = written_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_re        = 1'b0;
    ram_raddr     = ptr_r[AW-1:0];
    ram_we        = 1'b0;
    ram_waddr     = found_r ? hit_idx_r : count_r[AW-1:0];
    ram_wdata     = {key_r, rules.new_mark};

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = mode_t'(in_tdata[1:0]);
          key_nxt   = {in_tdata[33:2], in_tdata[65:34]};
          ptr_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue the next read while entries remain
        if (ptr_r != count_r) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
        end
        if (hit_now) begin
          found_nxt    = 1'b1;
          hit_idx_nxt  = rd_idx_r;
          hit_mark_nxt = mark_t'(ram_rdata[MARK_W-1:0]);
          rd_pend_nxt  = 1'b0;
          state_nxt    = S_WRITE;
        end else if (ptr_r == count_r) begin
          // Last live entry checked, or set empty: miss
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        // Commit once the result register can take the word
        if (out_free) begin
          ram_we        = rules.mem_we;
          count_nxt     = rules.alloc ? count_r + CW'(1) : count_r;
          inserts_nxt   = rules.inserts;
          written_nxt   = rules.written;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {rules.entry_kind, rules.inserts, rules.written,
                           rules.cancelled, rules.status};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ro_r        <= 1'b0;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      inserts_r   <= '0;
      written_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      inserts_r   <= inserts_nxt;
      written_r   <= written_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ro_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    mode_r     <= mode_nxt;
    ptr_r      <= ptr_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_mark_r <= hit_mark_nxt;
    out_data_r <= out_data_nxt;
  end

  // Fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SET_ENTRIES))
    else $error("set fill count exceeds table size");

  // A new result word is only loaded at the end of a write-back
  a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WRITE))
    else $error("result loaded outside write-back");

  // A hit always lies within the live entries
  a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && found_r) |-> (CW'(hit_idx_r) < count_r))
    else $error("hit index beyond fill count");

  // A full-table result never reports a mark
  a_full_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[2:0] == ST_FULL) |-> (out_data_r[14:12] == MK_NONE))
    else $error("full status with nonzero entry kind");

endmodule

`default_nettype wire
